@@ rtl/keypad_code_lock_controller_top_assert.svh @@
// Assertion macros shared by the keypad code lock RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_TOP_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define KCLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kclc assertion failed");

// Next-cycle implication, checked outside reset
`define KCLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kclc assertion failed");

`endif

@@ rtl/kclc_pkg.sv @@
// Shared types and constants for the keypad code lock controller.
// No dependencies.
package kclc_pkg;

    localparam int KEY_W   = 4;
    localparam int EVENT_W = 3;
    localparam int MODE_W  = 2;
    localparam int OUT_CNT_W = 3;
    localparam int FAIL_W  = 4;

    localparam logic [KEY_W-1:0]  KEY_DIGIT_MAX = 4'd9;
    localparam logic [KEY_W-1:0]  KEY_A         = 4'd10;
    localparam logic [FAIL_W-1:0] FAIL_MAX      = 4'd15;
    localparam logic [FAIL_W-1:0] LIMIT_RESET   = 4'd3;

    typedef enum logic [EVENT_W-1:0] {
        EV_IGNORED = 3'd0,
        EV_DIGIT   = 3'd1,
        EV_GRANTED = 3'd2,
        EV_DENIED  = 3'd3,
        EV_ALARM   = 3'd4,
        EV_CHANGE  = 3'd5,
        EV_LOCKED  = 3'd6,
        EV_SAVED   = 3'd7
    } kclc_event_t;

    // Control from the sequencer to the code store
    typedef struct packed {
        logic             take;   // write digit into the entry buffer
        logic             save;   // replace stored code, digit is the last one
        logic [KEY_W-1:0] digit;
    } kclc_buf_ctrl_t;

    // Factory code 1035, further digits zero
    function automatic logic [KEY_W-1:0] reset_digit(input int pos);
        logic [KEY_W-1:0] d;
        d = 4'd0;
        if (pos == 0)
            d = 4'd1;
        else if (pos == 2)
            d = 4'd3;
        else if (pos == 3)
            d = 4'd5;
        return d;
    endfunction

endpackage

@@ rtl/kclc_code_store.sv @@
// Stored code and entry buffer with the match compare for the code lock.
// Depends on kclc_pkg.
module kclc_code_store
    import kclc_pkg::*;
#(
    parameter int CODE_DIGITS = 4,
    parameter int CNT_W       = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  kclc_buf_ctrl_t   ctrl,
    input  logic [CNT_W-1:0] idx,
    output logic             match
);

    logic [KEY_W-1:0] stored_reg [CODE_DIGITS];
    logic [KEY_W-1:0] entry_reg  [CODE_DIGITS];

    // Compare buffered digits plus the incoming last digit
    always_comb
    begin
        match = (ctrl.digit == stored_reg[CODE_DIGITS-1]);
        for (int i = 0; i < CODE_DIGITS - 1; i++)
        begin
            if (entry_reg[i] != stored_reg[i])
                match = 1'b0;
        end
    end

    // Collect digits; contents are only read after being written
    always_ff @(posedge clk)
    begin
        if (ctrl.take)
            entry_reg[idx] <= ctrl.digit;
    end

    // Hold the stored code, load a new one on save
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CODE_DIGITS; i++)
                stored_reg[i] <= reset_digit(i);
        end
        else if (ctrl.save)
        begin
            for (int i = 0; i < CODE_DIGITS - 1; i++)
                stored_reg[i] <= entry_reg[i];
            stored_reg[CODE_DIGITS-1] <= ctrl.digit;
        end
    end

endmodule

@@ rtl/keypad_code_lock_controller_top.sv @@
// Top level of the keypad code lock controller: mode sequencer and result register.
// Depends on kclc_pkg, kclc_code_store and keypad_code_lock_controller_top_assert.svh.
//
// Usage:
//   Key beats arrive on key_code with in_valid/in_stall; one result beat per key
//   leaves on event_code, lock_mode, digits_entered and failed_count with
//   out_valid/out_stall. A beat moves when valid is high and stall is low.
//   Each key is handled in the cycle it is accepted; its result shows on the
//   outputs in the following cycle. One key per cycle is taken while the
//   output is free or being taken in the same cycle, so throughput is one beat
//   per cycle, set by the single registered update of mode, count and code.
//   When the receiver stalls a waiting result, in_stall rises and the result
//   holds until taken. The attempt limit is written through cfg_wr_en/cfg_wr_data;
//   the user must do so only while idle, which the block does not enforce.
//   Reset clears the mode to entry, the digit and failure counts to zero, the
//   limit to 3 and the stored code to 1035; no result is pending after reset.
`include "keypad_code_lock_controller_top_assert.svh"

module keypad_code_lock_controller_top
    import kclc_pkg::*;
#(
    parameter int CODE_DIGITS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [FAIL_W-1:0]    cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KEY_W-1:0]     key_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [EVENT_W-1:0]   event_code,
    output logic [MODE_W-1:0]    lock_mode,
    output logic [OUT_CNT_W-1:0] digits_entered,
    output logic [FAIL_W-1:0]    failed_count
);

    localparam int CNT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_DIGITS - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_ENTRY = 2'd0,
        MODE_MENU  = 2'd1,
        MODE_NEW   = 2'd2
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [FAIL_W-1:0]  failed_reg, failed_next;
    logic [FAIL_W-1:0]  limit_reg;
    kclc_event_t        event_next;
    logic               out_valid_reg;
    kclc_event_t        event_reg;
    mode_t              lock_mode_reg;
    logic [CNT_W-1:0]   digits_reg;
    logic [FAIL_W-1:0]  failed_out_reg;

    kclc_buf_ctrl_t     buf_ctrl;
    logic               accept;
    logic               is_digit;
    logic               is_last;
    logic               match;
    logic [FAIL_W-1:0]  failed_inc;

    // Take a key whenever the result register is free or draining
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_digit = (key_code <= KEY_DIGIT_MAX);
    assign is_last  = (count_reg == CNT_LAST);
    assign failed_inc = (failed_reg == FAIL_MAX) ? FAIL_MAX : failed_reg + 1'b1;

    kclc_code_store #(
        .CODE_DIGITS (CODE_DIGITS),
        .CNT_W       (CNT_W)
    ) u_code_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (buf_ctrl),
        .idx   (count_reg),
        .match (match)
    );

    // Decide the next mode, counts and event for the key at the input
    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        failed_next    = failed_reg;
        event_next     = EV_IGNORED;
        buf_ctrl.take  = 1'b0;
        buf_ctrl.save  = 1'b0;
        buf_ctrl.digit = key_code;
        unique case (mode_reg)
            MODE_MENU:
            begin
                count_next = '0;
                if (key_code == KEY_A)
                begin
                    mode_next  = MODE_NEW;
                    event_next = EV_CHANGE;
                end
                else
                begin
                    mode_next  = MODE_ENTRY;
                    event_next = EV_LOCKED;
                end
            end
            MODE_NEW:
            begin
                if (is_digit)
                begin
                    if (is_last)
                    begin
                        buf_ctrl.save = accept;
                        count_next    = '0;
                        mode_next     = MODE_ENTRY;
                        event_next    = EV_SAVED;
                    end
                    else
                    begin
                        buf_ctrl.take = accept;
                        count_next    = count_reg + 1'b1;
                        event_next    = EV_DIGIT;
                    end
                end
            end
            default:
            begin
                // Entry mode, and the unused code behaves the same way
                mode_next = MODE_ENTRY;
                if (is_digit)
                begin
                    if (is_last)
                    begin
                        count_next = '0;
                        if (match)
                        begin
                            failed_next = '0;
                            mode_next   = MODE_MENU;
                            event_next  = EV_GRANTED;
                        end
                        else if (failed_inc >= limit_reg)
                        begin
                            failed_next = '0;
                            event_next  = EV_ALARM;
                        end
                        else
                        begin
                            failed_next = failed_inc;
                            event_next  = EV_DENIED;
                        end
                    end
                    else
                    begin
                        buf_ctrl.take = accept;
                        count_next    = count_reg + 1'b1;
                        event_next    = EV_DIGIT;
                    end
                end
            end
        endcase
    end

    // Hold state and the result register; advance on each accepted key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_ENTRY;
            count_reg      <= '0;
            failed_reg     <= '0;
            limit_reg      <= LIMIT_RESET;
            out_valid_reg  <= 1'b0;
            event_reg      <= EV_IGNORED;
            lock_mode_reg  <= MODE_ENTRY;
            digits_reg     <= '0;
            failed_out_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (accept)
            begin
                mode_reg       <= mode_next;
                count_reg      <= count_next;
                failed_reg     <= failed_next;
                out_valid_reg  <= 1'b1;
                event_reg      <= event_next;
                lock_mode_reg  <= mode_next;
                digits_reg     <= count_next;
                failed_out_reg <= failed_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_code     = event_reg;
    assign lock_mode      = lock_mode_reg;
    assign digits_entered = OUT_CNT_W'(digits_reg);
    assign failed_count   = failed_out_reg;

    // An accepted key always leaves a result pending
    `KCLC_ASSERT_NEXT(a_accept_gives_result, accept, out_valid)
    // A grant opens the menu with a cleared failure count
    `KCLC_ASSERT_NOW(a_grant_opens_menu, out_valid_reg && event_reg == EV_GRANTED,
        lock_mode_reg == MODE_MENU && failed_out_reg == '0 && digits_reg == '0)
    // An alarm clears the failure count and stays in entry mode
    `KCLC_ASSERT_NOW(a_alarm_clears, out_valid_reg && event_reg == EV_ALARM,
        failed_out_reg == '0 && lock_mode_reg == MODE_ENTRY)
    // Any key in the menu restarts the digit count
    `KCLC_ASSERT_NEXT(a_menu_resets_count, accept && mode_reg == MODE_MENU,
        count_reg == '0)

endmodule

@@ verif/kclc_checker.sv @@
// Scoreboard for the keypad code lock controller: watches the key, result and
// config ports, predicts each result beat and compares it. Depends on kclc_pkg.
module kclc_checker
    import kclc_pkg::*;
#(
    parameter int CODE_DIGITS = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [FAIL_W-1:0]             cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [KEY_W-1:0]              key_code,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [EVENT_W-1:0]            event_code,
    input  logic [MODE_W-1:0]             lock_mode,
    input  logic [OUT_CNT_W-1:0]          digits_entered,
    input  logic [FAIL_W-1:0]             failed_count,
    output int                            error_count,
    output int                            results_due,
    output logic                          menu_open,
    output logic                          new_code_open,
    output logic [OUT_CNT_W-1:0]          entry_count,
    output logic [CODE_DIGITS*KEY_W-1:0]  code_now
);

    localparam logic [MODE_W-1:0] MODE_ENTRY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MENU  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEW   = 2'd2;

    // Factory code 1035, digit 0 in the low nibble
    localparam logic [15:0] FACTORY_CODE = 16'h5301;

    typedef struct packed {
        logic [EVENT_W-1:0]   ev;
        logic [MODE_W-1:0]    mode;
        logic [OUT_CNT_W-1:0] digits;
        logic [FAIL_W-1:0]    fails;
    } lock_result_t;

    lock_result_t      lock_results_due[$];
    logic [KEY_W-1:0]  code_q  [CODE_DIGITS];
    logic [KEY_W-1:0]  entry_q [CODE_DIGITS];
    int unsigned       count_q;
    logic [FAIL_W-1:0] fails_q;
    logic [FAIL_W-1:0] limit_q;
    logic [MODE_W-1:0] mode_q;
    int                mismatches;

    always @(posedge clk or negedge rst_n)
    begin : track_lock
        lock_result_t     seen;
        lock_result_t     want;
        kclc_event_t      ev;
        logic [KEY_W-1:0] k;
        bit               same;
        if (!rst_n)
        begin
            for (int i = 0; i < CODE_DIGITS; i++)
            begin
                code_q[i]  = (i < 4) ? FACTORY_CODE[i*4 +: 4] : '0;
                entry_q[i] = '0;
            end
            count_q    = 0;
            fails_q    = '0;
            limit_q    = LIMIT_RESET;
            mode_q     = MODE_ENTRY;
            mismatches = 0;
            lock_results_due.delete();
        end
        else
        begin
            // Compare a result beat against the oldest prediction
            if (out_valid && !out_stall)
            begin
                seen = {event_code, lock_mode, digits_entered, failed_count};
                if (lock_results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: ev=%0d mode=%0d digits=%0d fails=%0d",
                                 seen.ev, seen.mode, seen.digits, seen.fails);
                end
                else
                begin
                    want = lock_results_due.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected ev=%0d mode=%0d digits=%0d fails=%0d, got ev=%0d mode=%0d digits=%0d fails=%0d",
                                     want.ev, want.mode, want.digits, want.fails,
                                     seen.ev, seen.mode, seen.digits, seen.fails);
                    end
                end
            end

            // Track the attempt limit
            if (cfg_wr_en)
                limit_q = cfg_wr_data;

            // Advance the lock on each accepted key beat
            if (in_valid && !in_stall)
            begin
                k  = key_code;
                ev = EV_IGNORED;
                if (mode_q == MODE_MENU)
                begin
                    if (k == KEY_A)
                    begin
                        mode_q = MODE_NEW;
                        ev     = EV_CHANGE;
                    end
                    else
                    begin
                        mode_q = MODE_ENTRY;
                        ev     = EV_LOCKED;
                    end
                    count_q = 0;
                end
                else if (mode_q == MODE_NEW)
                begin
                    if (k <= KEY_DIGIT_MAX)
                    begin
                        ev = EV_DIGIT;
                        entry_q[count_q] = k;
                        count_q++;
                        if (count_q >= CODE_DIGITS)
                        begin
                            for (int i = 0; i < CODE_DIGITS; i++)
                                code_q[i] = entry_q[i];
                            count_q = 0;
                            mode_q  = MODE_ENTRY;
                            ev      = EV_SAVED;
                        end
                    end
                end
                else
                begin
                    // Unused mode value falls back to entry
                    mode_q = MODE_ENTRY;
                    if (k <= KEY_DIGIT_MAX)
                    begin
                        ev = EV_DIGIT;
                        entry_q[count_q] = k;
                        count_q++;
                        if (count_q >= CODE_DIGITS)
                        begin
                            count_q = 0;
                            same = 1'b1;
                            for (int i = 0; i < CODE_DIGITS; i++)
                                if (entry_q[i] != code_q[i])
                                    same = 1'b0;
                            if (same)
                            begin
                                fails_q = '0;
                                mode_q  = MODE_MENU;
                                ev      = EV_GRANTED;
                            end
                            else
                            begin
                                // Saturate before the limit compare
                                if (fails_q < FAIL_MAX)
                                    fails_q = fails_q + 1'b1;
                                if (fails_q >= limit_q)
                                begin
                                    fails_q = '0;
                                    ev      = EV_ALARM;
                                end
                                else
                                begin
                                    ev = EV_DENIED;
                                end
                            end
                        end
                    end
                end
                want.ev     = ev;
                want.mode   = mode_q;
                want.digits = count_q[OUT_CNT_W-1:0];
                want.fails  = fails_q;
                lock_results_due.push_back(want);
            end
        end

        // Publish status for the stimulus side
        error_count   <= mismatches;
        results_due   <= lock_results_due.size();
        menu_open     <= (mode_q == MODE_MENU);
        new_code_open <= (mode_q == MODE_NEW);
        entry_count   <= count_q[OUT_CNT_W-1:0];
        for (int i = 0; i < CODE_DIGITS; i++)
            code_now[i*KEY_W +: KEY_W] <= code_q[i];
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the keypad code lock controller: clock, reset, key and
// config stimulus, receiver stalls and the verdict. Depends on kclc_pkg,
// kclc_checker and keypad_code_lock_controller_top.
module tb;
    import kclc_pkg::*;

    localparam int CODE_DIGITS = 4;
    localparam int CODE_W      = CODE_DIGITS * KEY_W;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_KEYS = 400;
    localparam int PHASES      = 6;

    localparam logic [KEY_W-1:0] KEY_C    = 4'd12;
    localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [FAIL_W-1:0]    cfg_wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [KEY_W-1:0]     key_code;
    logic                 out_valid;
    logic                 out_stall;
    logic [EVENT_W-1:0]   event_code;
    logic [MODE_W-1:0]    lock_mode;
    logic [OUT_CNT_W-1:0] digits_entered;
    logic [FAIL_W-1:0]    failed_count;

    int                   error_count;
    int                   results_due;
    logic                 menu_open;
    logic                 new_code_open;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [CODE_W-1:0]    code_now;

    bit quiet;
    int keys_sent;
    int keys_scored;
    int limits_used;

    keypad_code_lock_controller_top #(
        .CODE_DIGITS(CODE_DIGITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .key_code(key_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_code(event_code),
        .lock_mode(lock_mode),
        .digits_entered(digits_entered),
        .failed_count(failed_count)
    );

    kclc_checker #(
        .CODE_DIGITS(CODE_DIGITS)
    ) lock_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .key_code(key_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_code(event_code),
        .lock_mode(lock_mode),
        .digits_entered(digits_entered),
        .failed_count(failed_count),
        .error_count(error_count),
        .results_due(results_due),
        .menu_open(menu_open),
        .new_code_open(new_code_open),
        .entry_count(entry_count),
        .code_now(code_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still due", CYCLE_LIMIT, results_due);
        $display("FAIL");
        $finish;
    end

    // Receiver: stall a random number of cycles, then take one beat
    initial
    begin
        int hold;
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Present one key beat after a random gap and hold it until taken
    task automatic send_key(input logic [KEY_W-1:0] k);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        key_code <= k;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        keys_sent++;
    endtask

    // Send the first n digits of a code, digit 0 in the low nibble
    task automatic send_code(input logic [CODE_W-1:0] code, input int n, input bit with_fill);
        logic [KEY_W-1:0] filler;
        for (int i = 0; i < n; i++)
        begin
            // Slip in a non-digit that the lock should drop
            if (with_fill && $urandom_range(0, 5) == 0)
            begin
                filler = KEY_A + KEY_W'($urandom_range(0, 5));
                send_key(filler);
            end
            send_key(code[i*KEY_W +: KEY_W]);
            keys_scored++;
        end
    endtask

    // Hold off until every result has come back, then let the pipe drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_limit(input logic [FAIL_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        limits_used++;
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        logic [CODE_W-1:0] code;
        int                pick;
        pick = $urandom_range(0, 7);
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            if (pick == 0)
                code[i*KEY_W +: KEY_W] = '0;
            else if (pick == 1)
                code[i*KEY_W +: KEY_W] = KEY_DIGIT_MAX;
            else
                code[i*KEY_W +: KEY_W] = KEY_W'($urandom_range(0, 9));
        end
        return code;
    endfunction

    initial
    begin
        logic [KEY_W-1:0]  k;
        logic [FAIL_W-1:0] limit_val;
        int                pick;
        int                target;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        key_code    <= '0;
        quiet       = 1'b0;
        keys_sent   = 0;
        keys_scored = 0;
        limits_used = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ignored keys, factory code, code change, lock from menu
        send_key(KEY_HASH);
        send_key(KEY_A);
        send_code(16'h5301, CODE_DIGITS, 1'b0);
        send_key(KEY_A);
        send_key(KEY_C);
        send_code(16'h9999, CODE_DIGITS, 1'b0);
        send_code(16'h9999, CODE_DIGITS, 1'b0);
        send_key(4'd0);
        send_code(16'h0000, CODE_DIGITS, 1'b0);
        send_code(16'h4321, CODE_DIGITS, 1'b0);
        // Drop the limit below the count, then to zero
        write_limit(4'd1);
        send_code(16'h2222, CODE_DIGITS, 1'b0);
        write_limit(4'd0);
        send_code(16'h7777, CODE_DIGITS, 1'b0);

        // Random sessions, each started from a drained pipe
        keys_scored = 0;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            unique case (phase)
                0: limit_val = FAIL_MAX;
                1: limit_val = LIMIT_RESET;
                2: limit_val = 4'd1;
                3: limit_val = 4'd0;
                default: limit_val = FAIL_W'($urandom_range(1, 14));
            endcase
            write_limit(limit_val);
            target = (phase + 1) * RANDOM_KEYS / PHASES;
            while (keys_scored < target)
            begin
                wait_idle();
                quiet = ($urandom_range(0, 7) == 0);
                if (menu_open)
                begin
                    // Choose a code change or lock again with any other key
                    if ($urandom_range(0, 1) == 1)
                    begin
                        k = KEY_A;
                    end
                    else
                    begin
                        k = KEY_W'($urandom_range(0, 14));
                        if (k >= KEY_A)
                            k = k + 1'b1;
                    end
                    send_key(k);
                    keys_scored++;
                end
                else if (new_code_open || entry_count != 0)
                begin
                    // Finish the pending entry
                    send_code(random_code(), CODE_DIGITS - int'(entry_count), 1'b1);
                end
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                    begin
                        send_code(code_now, CODE_DIGITS, 1'b1);
                    end
                    else if (pick < 7)
                    begin
                        repeat ($urandom_range(1, 16))
                            send_code(random_code(), CODE_DIGITS, 1'b1);
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 6))
                        begin
                            k = KEY_W'($urandom_range(0, 15));
                            send_key(k);
                            if (k <= KEY_DIGIT_MAX)
                                keys_scored++;
                        end
                    end
                end
            end
        end

        wait_idle();
        $display("Sent %0d keys through %0d attempt-limit settings with random gaps and stalls",
                 keys_sent, limits_used + 1);
        $display("Mismatches: %0d, results still due: %0d", error_count, results_due);
        if (error_count == 0 && results_due == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/kclc_pkg.sv
rtl/kclc_code_store.sv
rtl/keypad_code_lock_controller_top.sv
verif/kclc_checker.sv
verif/tb.sv
